>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("register block assertion failed");

// Checks an implication between two sampled conditions.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  `ASSERT_CLK(label, clk, rst, (ante) |-> (cons))

`endif

>>> hw/rtl/usrb_pkg.sv
package usrb_pkg;

  localparam int unsigned NumTransfersDefault = 10;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] XferBase = 8'h40;

  // Register offsets.
  localparam logic [7:0] REG_RESET      = 8'h08;
  localparam logic [7:0] REG_COMMAND    = 8'h10;
  localparam logic [7:0] REG_SPARE0     = 8'h14;
  localparam logic [7:0] REG_SPARE1     = 8'h18;
  localparam logic [7:0] REG_SPARE2     = 8'h1C;
  localparam logic [7:0] REG_IRQ_FLAGS  = 8'h20;
  localparam logic [7:0] REG_IRQ_CLEAR  = 8'h24;
  localparam logic [7:0] REG_IRQ_ENABLE = 8'h28;
  localparam logic [7:0] REG_IRQ_DIS    = 8'h2C;
  localparam logic [7:0] REG_SPARE3     = 8'h30;
  localparam logic [7:0] REG_SPARE4     = 8'h38;
  localparam logic [7:0] REG_SIZE       = 8'h90;
  localparam logic [7:0] REG_SPARE5     = 8'h94;

  // Access kinds.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // Command byte codes.
  localparam logic [7:0] OP_NOP1   = 8'h01;
  localparam logic [7:0] OP_NOP2   = 8'h02;
  localparam logic [7:0] OP_NOP3   = 8'h03;
  localparam logic [7:0] OP_SHORT  = 8'h04;
  localparam logic [7:0] OP_LONG   = 8'h05;
  localparam logic [7:0] OP_REGION = 8'h08;
  localparam logic [7:0] OP_SILENT = 8'h0B;

  localparam logic [4:0] ShortLen  = 5'd8;
  localparam logic [4:0] LongLen   = 5'd16;
  localparam logic [4:0] RegionLen = 5'd15;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_WORD = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    JOB_NONE   = 2'd0,
    JOB_SHORT  = 2'd1,
    JOB_LONG   = 2'd2,
    JOB_REGION = 2'd3
  } job_mode_t;

  // One classified access on its way from the front to the back.
  typedef struct packed {
    job_mode_t   mode;
    logic [31:0] base;
    logic [4:0]  count;
    logic [31:0] rdata;
    logic        irq;
    logic        pulse;
    logic        disc;
    logic        done;
    logic        fault;
  } job_t;

  function automatic logic [7:0] pat_short(input logic [2:0] i);
    logic [7:0] v;
    case (i)
      3'd0: v = 8'h12;
      3'd1: v = 8'h34;
      3'd2: v = 8'h56;
      3'd3: v = 8'h78;
      3'd4: v = 8'h9A;
      3'd5: v = 8'hBC;
      3'd6: v = 8'hDE;
      default: v = 8'hF0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pat_long(input logic [3:0] i);
    logic [7:0] v;
    case (i)
      4'd0: v = 8'h0F;
      4'd1: v = 8'hED;
      4'd2: v = 8'hCB;
      4'd3: v = 8'hA9;
      4'd4: v = 8'h87;
      4'd5: v = 8'h65;
      4'd6: v = 8'h43;
      4'd7: v = 8'h21;
      default: v = pat_short(i[2:0]);
    endcase
    return v;
  endfunction

  function automatic logic [6:0] region_off(input logic [3:0] i);
    logic [6:0] v;
    case (i)
      4'd0: v = 7'd0;
      4'd1: v = 7'd4;
      4'd2: v = 7'd12;
      4'd3: v = 7'd40;
      4'd4: v = 7'd44;
      4'd5: v = 7'd48;
      4'd6: v = 7'd52;
      4'd7: v = 7'd56;
      4'd8: v = 7'd60;
      4'd9: v = 7'd64;
      4'd10: v = 7'd68;
      4'd11: v = 7'd72;
      4'd12: v = 7'd76;
      4'd13: v = 7'd80;
      default: v = 7'd84;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] region_val(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0: v = 32'h1234_5678;
      4'd2: v = 32'd2;
      4'd3: v = 32'h0000_000F;
      4'd4: v = 32'h8000_0000;
      4'd9: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/usrb_front.sv
module usrb_front #(
  parameter int unsigned NUM_TRANSFERS = usrb_pkg::NumTransfersDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           cmd,
  input  logic [7:0]     reg_offset,
  input  logic [31:0]    wdata,
  input  logic           disc_present,
  output usrb_pkg::job_t job
);
  import usrb_pkg::*;

  localparam int unsigned XferEndInt = 64 + 8 * NUM_TRANSFERS;
  localparam logic [8:0] XferEnd = 9'(XferEndInt);

  // Only transfer 0 and the readable registers feed any result; the other
  // transfer pairs, the size word and spare 5 are write-only and never observed.
  logic [31:0] reset_word, reset_word_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [31:0] irq_flags, irq_flags_next;
  logic [31:0] irq_enables, irq_enables_next;
  logic [31:0] xfer_addr0, xfer_addr0_next;
  logic [31:0] xfer_len0, xfer_len0_next;
  logic [31:0] spare1, spare1_next;
  logic [31:0] spare3, spare3_next;
  logic [31:0] spare4, spare4_next;

  logic in_window;

  assign in_window = (reg_offset >= XferBase) && ({1'b0, reg_offset} < XferEnd);

  always_comb begin
    reset_word_next   = reset_word;
    command_byte_next = command_byte;
    irq_flags_next    = irq_flags;
    irq_enables_next  = irq_enables;
    xfer_addr0_next   = xfer_addr0;
    xfer_len0_next    = xfer_len0;
    spare1_next       = spare1;
    spare3_next       = spare3;
    spare4_next       = spare4;

    job.mode  = JOB_NONE;
    job.base  = xfer_addr0;
    job.count = 5'd0;
    job.rdata = 32'd0;
    job.pulse = 1'b0;
    job.disc  = 1'b0;
    job.done  = 1'b0;
    job.fault = 1'b0;

    if (cmd == ACC_WRITE) begin
      if (in_window) begin
        if (reg_offset[7:3] == XferBase[7:3]) begin
          if (reg_offset[2]) begin
            xfer_len0_next = wdata;
          end else begin
            xfer_addr0_next = wdata;
          end
        end
      end else begin
        case (reg_offset)
          REG_RESET: begin
            reset_word_next = {wdata[31:1], 1'b0};
            job.pulse = wdata[0];
            job.disc  = wdata[0] & disc_present;
          end
          REG_COMMAND: begin
            command_byte_next = wdata[7:0];
            case (wdata[7:0])
              OP_SILENT: ;
              OP_NOP1, OP_NOP2, OP_NOP3: irq_flags_next = irq_flags | 32'd1;
              OP_SHORT: begin
                job.mode  = JOB_SHORT;
                job.count = (xfer_len0 < 32'(ShortLen)) ? xfer_len0[4:0] : ShortLen;
                irq_flags_next = irq_flags | 32'd1;
              end
              OP_LONG: begin
                job.mode  = JOB_LONG;
                job.count = (xfer_len0 < 32'(LongLen)) ? xfer_len0[4:0] : LongLen;
                irq_flags_next = irq_flags | 32'd1;
              end
              OP_REGION: begin
                job.mode  = JOB_REGION;
                job.count = RegionLen;
                job.done  = 1'b1;
                irq_flags_next = irq_flags | 32'd1;
              end
              default: job.fault = 1'b1;
            endcase
          end
          REG_SPARE1:     spare1_next = wdata;
          REG_IRQ_CLEAR:  irq_flags_next = irq_flags & ~wdata;
          REG_IRQ_ENABLE: irq_enables_next = irq_enables | wdata;
          REG_IRQ_DIS:    irq_enables_next = irq_enables & ~wdata;
          REG_SPARE3:     spare3_next = wdata;
          REG_SPARE4:     spare4_next = wdata;
          REG_SIZE, REG_SPARE5: ;
          default: job.fault = 1'b1;
        endcase
      end
    end else begin
      case (reg_offset)
        REG_RESET:      job.rdata = reset_word;
        REG_COMMAND:    job.rdata = {24'd0, command_byte};
        REG_SPARE0:     job.rdata = 32'd0;
        REG_SPARE1:     job.rdata = spare1;
        REG_SPARE2:     job.rdata = 32'd0;
        REG_IRQ_FLAGS:  job.rdata = irq_flags;
        REG_IRQ_CLEAR:  job.rdata = 32'd0;
        REG_IRQ_ENABLE: job.rdata = irq_enables;
        REG_IRQ_DIS:    job.rdata = 32'd0;
        REG_SPARE3:     job.rdata = spare3;
        REG_SPARE4:     job.rdata = spare4;
        default:        job.fault = 1'b1;
      endcase
    end

    // The interrupt line reflects the state after this transaction.
    job.irq = |(irq_flags_next & irq_enables_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_word   <= 32'd0;
      command_byte <= 8'd0;
      irq_flags    <= 32'd0;
      irq_enables  <= 32'd0;
      xfer_addr0   <= 32'd0;
      xfer_len0    <= 32'd0;
      spare1       <= 32'd0;
      spare3       <= 32'd0;
      spare4       <= 32'd0;
    end else if (accept) begin
      reset_word   <= reset_word_next;
      command_byte <= command_byte_next;
      irq_flags    <= irq_flags_next;
      irq_enables  <= irq_enables_next;
      xfer_addr0   <= xfer_addr0_next;
      xfer_len0    <= xfer_len0_next;
      spare1       <= spare1_next;
      spare3       <= spare3_next;
      spare4       <= spare4_next;
    end
  end

endmodule

>>> hw/rtl/usrb_queue.sv
module usrb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  usrb_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output usrb_pkg::job_t rd_job
);
  import usrb_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  job_t entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/usrb_back.sv
module usrb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  usrb_pkg::job_t job,
  output logic           job_pop,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     kind,
  output logic [31:0]    rdata,
  output logic [31:0]    mem_addr,
  output logic [31:0]    mem_data,
  output logic           irq_line,
  output logic           pin_pulse,
  output logic           disc_pin,
  output logic           scsi_done,
  output logic           fault,
  output logic           last
);
  import usrb_pkg::*;

  logic        out_valid;
  logic        load;
  logic        emit_mem;
  logic [4:0]  idx;
  logic [1:0]  kind_next;
  logic [31:0] addr_next;
  logic [31:0] data_next;

  // The output register is refilled in the same cycle its result is taken, when a job is waiting.
  assign load     = job_valid && (!out_valid || pop);
  assign emit_mem = (idx < job.count);
  assign job_pop  = load && !emit_mem;
  assign empty    = !out_valid;

  always_comb begin
    kind_next = KIND_DONE;
    addr_next = 32'd0;
    data_next = 32'd0;
    if (emit_mem) begin
      case (job.mode)
        JOB_SHORT: begin
          kind_next = KIND_BYTE;
          addr_next = job.base + 32'(idx);
          data_next = {24'd0, pat_short(idx[2:0])};
        end
        JOB_LONG: begin
          kind_next = KIND_BYTE;
          addr_next = job.base + 32'(idx);
          data_next = {24'd0, pat_long(idx[3:0])};
        end
        JOB_REGION: begin
          kind_next = KIND_WORD;
          addr_next = job.base + 32'(region_off(idx[3:0]));
          data_next = region_val(idx[3:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 5'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= emit_mem ? idx + 5'd1 : 5'd0;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind      <= kind_next;
      mem_addr  <= addr_next;
      mem_data  <= data_next;
      rdata     <= emit_mem ? 32'd0 : job.rdata;
      irq_line  <= !emit_mem && job.irq;
      pin_pulse <= !emit_mem && job.pulse;
      disc_pin  <= !emit_mem && job.disc;
      scsi_done <= !emit_mem && job.done;
      fault     <= !emit_mem && job.fault;
      last      <= !emit_mem;
    end
  end

endmodule

>>> hw/rtl/umd_security_register_block.sv
// A transaction passes through the two-entry job queue and then the back end's output
// register before its completion shows on the result ports; a command write first emits its
// memory writes. Throughput: one result per cycle from the back end while results are popped;
// a command write yields up to 16 byte writes plus completion, other accesses completion only.
// Reset: rst is synchronous and active high; it clears the registers, the queue pointers and
// the result valid flag, while the result data registers keep their contents.
module umd_security_register_block #(
  parameter int unsigned NUM_TRANSFERS = usrb_pkg::NumTransfersDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  reg_offset,
  input  logic [31:0] wdata,
  input  logic        disc_present,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [31:0] rdata,
  output logic [31:0] mem_addr,
  output logic [31:0] mem_data,
  output logic        irq_line,
  output logic        pin_pulse,
  output logic        disc_pin,
  output logic        scsi_done,
  output logic        fault,
  output logic        last
);
  import usrb_pkg::*;

  logic accept;
  job_t front_job;
  job_t head_job;
  logic head_valid;
  logic head_pop;

  assign accept = push && !full;

  usrb_front #(
    .NUM_TRANSFERS(NUM_TRANSFERS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (cmd),
    .reg_offset   (reg_offset),
    .wdata        (wdata),
    .disc_present (disc_present),
    .job          (front_job)
  );

  usrb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_job   (front_job),
    .full     (full),
    .rd_en    (head_pop),
    .rd_valid (head_valid),
    .rd_job   (head_job)
  );

  usrb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (head_pop),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .rdata     (rdata),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data),
    .irq_line  (irq_line),
    .pin_pulse (pin_pulse),
    .disc_pin  (disc_pin),
    .scsi_done (scsi_done),
    .fault     (fault),
    .last      (last)
  );

endmodule

>>> hw/rtl/usrb_checker.sv
`include "assert_macros.svh"

module usrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind,
  input logic [31:0] rdata,
  input logic        pin_pulse,
  input logic        disc_pin,
  input logic        scsi_done,
  input logic        fault,
  input logic        last
);
  import usrb_pkg::*;

  // A waiting result that is not taken stays on the ports.
  `ASSERT_CLK(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(kind) && $stable(last)))

  // Only the completion of a transaction is marked last.
  `ASSERT_IMPLY(a_last_kind, clk, rst, !empty, last == (kind == KIND_DONE))

  // Memory writes carry none of the completion status.
  `ASSERT_IMPLY(a_mem_clean, clk, rst, !empty && kind != KIND_DONE,
                rdata == 32'd0 && !pin_pulse && !scsi_done && !fault)

  // The disc level is only reported with a pin pulse.
  `ASSERT_IMPLY(a_disc_pulse, clk, rst, !empty && disc_pin, pin_pulse)

endmodule

bind umd_security_register_block usrb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .kind      (kind),
  .rdata     (rdata),
  .pin_pulse (pin_pulse),
  .disc_pin  (disc_pin),
  .scsi_done (scsi_done),
  .fault     (fault),
  .last      (last)
);
